/* sv/aqi_pkg.sv */
`timescale 1ns / 1ps
// Shared types, breakpoint tables and reciprocal constants for the AQI block.
// Depends on nothing; every other file in sv/ imports it.
package aqi_pkg;

    localparam int POLL_COUNT    = 6;
    localparam int SEGMENT_COUNT = 6;
    localparam int CONC_W        = 15;
    localparam int SEG_W         = 3;
    localparam int DIFF_W        = 13;   // widest segment span is 7990 tenths
    localparam int RECIP_W       = 29;
    localparam int RECIP_SHIFT   = 26;   // 2**26 exceeds span*span for every segment
    localparam int PROD_W        = DIFF_W + RECIP_W;
    localparam int QUOT_W        = 7;    // interpolated rise never exceeds 99
    localparam int AQI_W         = 9;
    localparam int CAT_W         = 3;

    typedef logic [CONC_W-1:0] conc_t;
    typedef logic [AQI_W-1:0]  aqi_t;
    typedef logic [CAT_W-1:0]  cat_t;
    typedef logic [SEG_W-1:0]  seg_t;

    typedef struct packed {
        logic adv_a;
        logic adv_b;
        logic adv_c;
    } lane_adv_t;

    typedef struct packed {
        logic adv_d;
        logic adv_e;
    } merge_adv_t;

    // Category levels and their upper AQI limits
    localparam cat_t CAT_GOOD         = 3'd0;
    localparam cat_t CAT_SATISFACTORY = 3'd1;
    localparam cat_t CAT_MODERATE     = 3'd2;
    localparam cat_t CAT_POOR         = 3'd3;
    localparam cat_t CAT_VERY_POOR    = 3'd4;
    localparam cat_t CAT_SEVERE       = 3'd5;

    localparam aqi_t LIM_GOOD         = 9'd50;
    localparam aqi_t LIM_SATISFACTORY = 9'd100;
    localparam aqi_t LIM_MODERATE     = 9'd200;
    localparam aqi_t LIM_POOR         = 9'd300;
    localparam aqi_t LIM_VERY_POOR    = 9'd400;

    localparam conc_t CONC_LOW [POLL_COUNT][SEGMENT_COUNT] = '{
        '{15'd0, 15'd310, 15'd610,  15'd910,  15'd1210, 15'd2510},
        '{15'd0, 15'd510, 15'd1010, 15'd2510, 15'd3510, 15'd4310},
        '{15'd0, 15'd410, 15'd810,  15'd1810, 15'd2810, 15'd4010},
        '{15'd0, 15'd410, 15'd810,  15'd3810, 15'd8010, 15'd16010},
        '{15'd0, 15'd11,  15'd21,   15'd101,  15'd171,  15'd341},
        '{15'd0, 15'd510, 15'd1010, 15'd1690, 15'd2090, 15'd7490}
    };

    localparam conc_t CONC_HIGH [POLL_COUNT][SEGMENT_COUNT] = '{
        '{15'd300, 15'd600,  15'd900,  15'd1200, 15'd2500,  15'd5000},
        '{15'd500, 15'd1000, 15'd2500, 15'd3500, 15'd4300,  15'd5000},
        '{15'd400, 15'd800,  15'd1800, 15'd2800, 15'd4000,  15'd10000},
        '{15'd400, 15'd800,  15'd3800, 15'd8000, 15'd16000, 15'd20000},
        '{15'd10,  15'd20,   15'd100,  15'd170,  15'd340,   15'd500},
        '{15'd500, 15'd1000, 15'd1680, 15'd2080, 15'd7480,  15'd10000}
    };

    localparam aqi_t INDEX_LOW [SEGMENT_COUNT] = '{
        9'd0, 9'd51, 9'd101, 9'd201, 9'd301, 9'd401
    };

    // ceil(rise * 2**RECIP_SHIFT / span): floor(diff * RECIP >> RECIP_SHIFT)
    // equals floor(rise * diff / span) for every diff within the span.
    localparam logic [63:0] SCALE = 64'd1 << RECIP_SHIFT;

    localparam logic [63:0] RECIP_TAB [POLL_COUNT][SEGMENT_COUNT] = '{
        '{(50*SCALE + 299) / 300,   (49*SCALE + 289) / 290,
          (99*SCALE + 289) / 290,   (99*SCALE + 289) / 290,
          (99*SCALE + 1289) / 1290, (99*SCALE + 2489) / 2490},
        '{(50*SCALE + 499) / 500,   (49*SCALE + 489) / 490,
          (99*SCALE + 1489) / 1490, (99*SCALE + 989) / 990,
          (99*SCALE + 789) / 790,   (99*SCALE + 689) / 690},
        '{(50*SCALE + 399) / 400,   (49*SCALE + 389) / 390,
          (99*SCALE + 989) / 990,   (99*SCALE + 989) / 990,
          (99*SCALE + 1189) / 1190, (99*SCALE + 5989) / 5990},
        '{(50*SCALE + 399) / 400,   (49*SCALE + 389) / 390,
          (99*SCALE + 2989) / 2990, (99*SCALE + 4189) / 4190,
          (99*SCALE + 7989) / 7990, (99*SCALE + 3989) / 3990},
        '{(50*SCALE + 9) / 10,      (49*SCALE + 8) / 9,
          (99*SCALE + 78) / 79,     (99*SCALE + 68) / 69,
          (99*SCALE + 168) / 169,   (99*SCALE + 158) / 159},
        '{(50*SCALE + 499) / 500,   (49*SCALE + 489) / 490,
          (99*SCALE + 669) / 670,   (99*SCALE + 389) / 390,
          (99*SCALE + 5389) / 5390, (99*SCALE + 2509) / 2510}
    };

endpackage

/* sv/aqi_lane.sv */
`timescale 1ns / 1ps
// One pollutant lane: segment search, reciprocal interpolation, sub-index.
// Depends on aqi_pkg; instantiated once per pollutant by the top level.
module aqi_lane #(
    parameter int POLL_IDX = 0
) (
    input  logic              clk,
    input  aqi_pkg::lane_adv_t adv,
    input  aqi_pkg::conc_t    conc,
    output aqi_pkg::aqi_t     sub_index,
    output logic              in_table
);
    import aqi_pkg::*;

    // stage A: segment select
    logic [SEGMENT_COUNT-1:0] hit;
    seg_t                     seg_a_next, seg_a_reg;
    logic                     gap_a_next, gap_a_reg;
    logic                     above_a_next, above_a_reg;
    logic [DIFF_W-1:0]        diff_a_next, diff_a_reg;
    conc_t                    lo_sel;
    conc_t                    diff_full;

    always_comb
    begin
        seg_a_next = '0;
        for (int s = SEGMENT_COUNT - 1; s >= 0; s--)
        begin
            hit[s] = (conc <= CONC_HIGH[POLL_IDX][s]);
            if (hit[s])
            begin
                seg_a_next = SEG_W'(s);
            end
        end
        above_a_next = ~|hit;
        lo_sel       = CONC_LOW[POLL_IDX][seg_a_next];
        gap_a_next   = (conc < lo_sel);
        diff_full    = conc - lo_sel;
        diff_a_next  = gap_a_next ? '0 : diff_full[DIFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.adv_a)
        begin
            seg_a_reg   <= seg_a_next;
            gap_a_reg   <= gap_a_next;
            above_a_reg <= above_a_next;
            diff_a_reg  <= diff_a_next;
        end
    end

    // stage B: multiply by reciprocal, keep the integer part
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot_b_next, quot_b_reg;
    seg_t               seg_b_reg;
    logic               above_b_reg;

    always_comb
    begin
        recip       = RECIP_TAB[POLL_IDX][seg_a_reg][RECIP_W-1:0];
        prod        = PROD_W'(diff_a_reg) * PROD_W'(recip);
        quot_b_next = gap_a_reg ? '0 : prod[RECIP_SHIFT +: QUOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv.adv_b)
        begin
            quot_b_reg  <= quot_b_next;
            seg_b_reg   <= seg_a_reg;
            above_b_reg <= above_a_reg;
        end
    end

    // stage C: add segment base index
    aqi_t sub_c_next, sub_c_reg;
    logic ok_c_reg;

    assign sub_c_next = INDEX_LOW[seg_b_reg] + AQI_W'(quot_b_reg);

    always_ff @(posedge clk)
    begin
        if (adv.adv_c)
        begin
            sub_c_reg <= sub_c_next;
            ok_c_reg  <= ~above_b_reg;
        end
    end

    assign sub_index = sub_c_reg;
    assign in_table  = ok_c_reg;

endmodule

/* sv/aqi_merge.sv */
`timescale 1ns / 1ps
// Merge stage: maximum over the lanes, above-table mask, category, output register.
// Depends on aqi_pkg.
module aqi_merge (
    input  logic                                         clk,
    input  aqi_pkg::merge_adv_t                          adv,
    input  aqi_pkg::aqi_t [aqi_pkg::POLL_COUNT-1:0]      sub_index,
    input  logic [aqi_pkg::POLL_COUNT-1:0]               in_table,
    output aqi_pkg::aqi_t                                aqi_value,
    output aqi_pkg::cat_t                                category_level,
    output logic [aqi_pkg::POLL_COUNT-1:0]               above_table_mask,
    output logic                                         none_valid
);
    import aqi_pkg::*;

    // stage D: maximum of the in-table lanes
    aqi_t                  best_d_next, best_d_reg;
    logic [POLL_COUNT-1:0] mask_d_reg;

    always_comb
    begin
        best_d_next = '0;
        for (int i = 0; i < POLL_COUNT; i++)
        begin
            if (in_table[i] && (sub_index[i] > best_d_next))
            begin
                best_d_next = sub_index[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.adv_d)
        begin
            best_d_reg <= best_d_next;
            mask_d_reg <= ~in_table;
        end
    end

    // stage E: category and output register
    cat_t cat_e_next;
    aqi_t aqi_e_reg;
    cat_t cat_e_reg;
    logic [POLL_COUNT-1:0] mask_e_reg;
    logic none_e_reg;

    always_comb
    begin
        if (best_d_reg <= LIM_GOOD)
            cat_e_next = CAT_GOOD;
        else if (best_d_reg <= LIM_SATISFACTORY)
            cat_e_next = CAT_SATISFACTORY;
        else if (best_d_reg <= LIM_MODERATE)
            cat_e_next = CAT_MODERATE;
        else if (best_d_reg <= LIM_POOR)
            cat_e_next = CAT_POOR;
        else if (best_d_reg <= LIM_VERY_POOR)
            cat_e_next = CAT_VERY_POOR;
        else
            cat_e_next = CAT_SEVERE;
    end

    always_ff @(posedge clk)
    begin
        if (adv.adv_e)
        begin
            aqi_e_reg  <= best_d_reg;
            cat_e_reg  <= cat_e_next;
            mask_e_reg <= mask_d_reg;
            none_e_reg <= &mask_d_reg;
        end
    end

    assign aqi_value        = aqi_e_reg;
    assign category_level   = cat_e_reg;
    assign above_table_mask = mask_e_reg;
    assign none_valid       = none_e_reg;

endmodule

/* sv/air_quality_index_calc.sv */
`timescale 1ns / 1ps
// Top level of the national air quality index block: six pollutant lanes and a merge stage.
// Depends on aqi_pkg, aqi_lane and aqi_merge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat of six concentrations in
//   tenths of their unit. Output channel (out_valid/out_ready) returns one beat
//   per input beat: AQI, category level, above-table mask and an all-excluded flag.
//   The path from the accepting edge to out_valid runs through five register
//   stages (segment search, reciprocal multiply, base add, lane maximum,
//   category/output register), the first loaded at the accepting edge itself.
//   Throughput is one beat per cycle while out_ready holds high; the six lanes run
//   side by side and each pipeline stage holds its own beat.
//   Each stage advances when it is empty or the stage after it advances, so a
//   stalled receiver holds only the beats it must; bubbles collapse and in_ready
//   stays high unless all five stages are full and out_ready is low.
//   Reset clears the stage valid bits only; the pipeline comes out empty with
//   in_ready high. Data registers carry no reset.
module air_quality_index_calc (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aqi_pkg::conc_t       pm25_tenths,
    input  aqi_pkg::conc_t       pm10_tenths,
    input  aqi_pkg::conc_t       no2_tenths,
    input  aqi_pkg::conc_t       so2_tenths,
    input  aqi_pkg::conc_t       co_tenths,
    input  aqi_pkg::conc_t       o3_tenths,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aqi_pkg::aqi_t        aqi_value,
    output aqi_pkg::cat_t        category_level,
    output logic [5:0]           above_table_mask,
    output logic                 none_valid
);
    import aqi_pkg::*;

    // Stage valid bits, one per pipeline stage
    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg, vld_e_reg;
    logic vld_a_next, vld_b_next, vld_c_next, vld_d_next, vld_e_next;

    lane_adv_t  lane_adv;
    merge_adv_t merge_adv;

    // Advance from the output backward: a stage moves when empty or drained
    always_comb
    begin
        merge_adv.adv_e = ~vld_e_reg | out_ready;
        merge_adv.adv_d = ~vld_d_reg | merge_adv.adv_e;
        lane_adv.adv_c  = ~vld_c_reg | merge_adv.adv_d;
        lane_adv.adv_b  = ~vld_b_reg | lane_adv.adv_c;
        lane_adv.adv_a  = ~vld_a_reg | lane_adv.adv_b;

        vld_a_next = lane_adv.adv_a  ? in_valid  : vld_a_reg;
        vld_b_next = lane_adv.adv_b  ? vld_a_reg : vld_b_reg;
        vld_c_next = lane_adv.adv_c  ? vld_b_reg : vld_c_reg;
        vld_d_next = merge_adv.adv_d ? vld_c_reg : vld_d_reg;
        vld_e_next = merge_adv.adv_e ? vld_d_reg : vld_e_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= vld_a_next;
            vld_b_reg <= vld_b_next;
            vld_c_reg <= vld_c_next;
            vld_d_reg <= vld_d_next;
            vld_e_reg <= vld_e_next;
        end
    end

    assign in_ready  = lane_adv.adv_a;
    assign out_valid = vld_e_reg;

    // Lane order fixes the mask bit order: bit 0 is PM2.5
    conc_t [POLL_COUNT-1:0] conc;
    aqi_t  [POLL_COUNT-1:0] sub_index;
    logic  [POLL_COUNT-1:0] in_table;

    assign conc[0] = pm25_tenths;
    assign conc[1] = pm10_tenths;
    assign conc[2] = no2_tenths;
    assign conc[3] = so2_tenths;
    assign conc[4] = co_tenths;
    assign conc[5] = o3_tenths;

    for (genvar p = 0; p < POLL_COUNT; p++)
    begin : g_lane
        aqi_lane #(
            .POLL_IDX (p)
        ) u_lane (
            .clk       (clk),
            .adv       (lane_adv),
            .conc      (conc[p]),
            .sub_index (sub_index[p]),
            .in_table  (in_table[p])
        );
    end

    aqi_merge u_merge (
        .clk              (clk),
        .adv              (merge_adv),
        .sub_index        (sub_index),
        .in_table         (in_table),
        .aqi_value        (aqi_value),
        .category_level   (category_level),
        .above_table_mask (above_table_mask),
        .none_valid       (none_valid)
    );

`ifndef SYNTHESIS
    // An all-excluded beat reports AQI 0 in the good category
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none_valid |-> (aqi_value == '0) && (category_level == CAT_GOOD))
        else $error("none_valid beat with nonzero AQI or category");

    // The flag and the mask come from the same lane outcome
    a_none_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (none_valid == (&above_table_mask)))
        else $error("none_valid disagrees with above_table_mask");

    // Category matches the AQI band at the low and high ends
    a_cat_band: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((aqi_value <= LIM_GOOD) == (category_level == CAT_GOOD)) &&
                      ((aqi_value > LIM_VERY_POOR) == (category_level == CAT_SEVERE)))
        else $error("category level out of step with AQI");

    // An accepted beat always lands in the first stage
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_a_reg)
        else $error("accepted beat lost at stage A");

    // A held output beat stays put while the receiver stalls
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(aqi_value) && $stable(none_valid))
        else $error("stalled output beat changed");
`endif

endmodule
